### src/ltk_pkg.sv
// Package for the longest-interval top-K tracker.
// Holds the command and status codes and the word and entry types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ltk_pkg;

  localparam int unsigned TsW   = 63;
  localparam int unsigned SiteW = 32;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_END   = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CLEAR = 2'd3
  } ltk_cmd_e;

  typedef enum logic [2:0] {
    ST_STARTED   = 3'd0,
    ST_IGNORED   = 3'd1,
    ST_INSERTED  = 3'd2,
    ST_DISCARDED = 3'd3,
    ST_READ      = 3'd4,
    ST_EMPTY     = 3'd5,
    ST_CLEARED   = 3'd6
  } ltk_status_e;

  typedef struct packed {
    ltk_cmd_e               command;
    logic [TsW-1:0]         timestamp;
    logic [SiteW-1:0]       site_tag;
    logic [2:0]             read_index;
  } in_word_t;

  typedef struct packed {
    ltk_status_e            status;
    logic [2:0]             position;
    logic [3:0]             entry_count;
    logic [TsW-1:0]         total_ticks;
    logic [TsW-1:0]         entry_duration;
    logic [TsW-1:0]         entry_start;
    logic [SiteW-1:0]       entry_site;
  } out_word_t;

  typedef struct packed {
    logic [TsW-1:0]         duration;
    logic [TsW-1:0]         start;
    logic [SiteW-1:0]       site;
  } ltk_entry_t;

  typedef struct packed {
    logic                   en;
    ltk_entry_t             entry;
  } ltk_ins_t;

endpackage

`default_nettype wire

### src/longest_interval_top_k_tracker_unit.sv
// Top level of the longest-interval top-K tracker.
// Depends on ltk_pkg and ltk_cell.
//
// The tracker takes one command word per cycle and answers each with one
// result word, held in an output register. Intervals are kept in a row of
// KEEP_DEPTH cells sorted by descending duration; on an end command every
// cell compares its duration with the new one at once and either stays,
// takes the new interval or takes its neighbor's entry, so all cells take
// their new entries together on an insertion. Input is stalled only while a
// result word waits and the output side stalls.
`timescale 1ns / 1ps
`default_nettype none

module longest_interval_top_k_tracker_unit #(
  parameter int unsigned KEEP_DEPTH = 8
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  ltk_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output ltk_pkg::out_word_t out_word_o
);
  import ltk_pkg::*;

  localparam int unsigned IdxW = (KEEP_DEPTH > 1) ? $clog2(KEEP_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(KEEP_DEPTH + 1);
  localparam int unsigned PosW = (IdxW > 3) ? IdxW : 3;
  localparam int unsigned CxW  = (CntW > 4) ? CntW : 4;
  localparam int unsigned RdW  = (CntW > 3) ? CntW : 3;

  logic               accept;
  logic               tracking_q, tracking_d;
  logic [TsW-1:0]     open_q, open_d;
  logic [CntW-1:0]    count_q, count_d;
  logic [TsW-1:0]     total_q, total_d;
  logic               out_valid_q, out_valid_d;
  out_word_t          out_word_q, out_word_d;

  logic [TsW-1:0]     duration;
  logic [TsW:0]       sum;
  logic [TsW-1:0]     total_sat;
  ltk_ins_t           ins;
  ltk_entry_t         cell_entry [KEEP_DEPTH];
  logic [KEEP_DEPTH-1:0] keep_vec;
  logic [KEEP_DEPTH-1:0] prev_keep_vec;
  logic [PosW-1:0]    ins_pos;
  logic               discard;
  logic [RdW-1:0]     read_idx;
  logic               read_hit;
  ltk_entry_t         read_entry;
  logic [CxW-1:0]     count_ext;

  assign in_stall_o  = out_valid_q && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  assign duration  = (in_word_i.timestamp >= open_q) ? (in_word_i.timestamp - open_q) : '0;
  assign sum       = {1'b0, total_q} + {1'b0, duration};
  assign total_sat = sum[TsW] ? {TsW{1'b1}} : sum[TsW-1:0];

  assign ins.en             = accept && (in_word_i.command == CMD_END) && tracking_q;
  assign ins.entry.duration = duration;
  assign ins.entry.start    = open_q;
  assign ins.entry.site     = in_word_i.site_tag;

  for (genvar i = 0; i < KEEP_DEPTH; i++) begin : g_cell
    ltk_entry_t prev_entry;
    if (i == 0) begin : g_head
      assign prev_keep_vec[i] = 1'b1;
      assign prev_entry       = ins.entry;
    end else begin : g_body
      assign prev_keep_vec[i] = keep_vec[i-1];
      assign prev_entry       = cell_entry[i-1];
    end
    ltk_cell u_cell (
      .clk_i        (clk_i),
      .ins_i        (ins),
      .occupied_i   (CntW'(i) < count_q),
      .prev_keep_i  (prev_keep_vec[i]),
      .prev_entry_i (prev_entry),
      .keep_o       (keep_vec[i]),
      .entry_o      (cell_entry[i])
    );
  end

  assign discard = keep_vec[KEEP_DEPTH-1];

  always_comb begin
    ins_pos = '0;
    for (int i = 0; i < KEEP_DEPTH; i++) begin
      if (prev_keep_vec[i] && !keep_vec[i]) begin
        ins_pos = ins_pos | PosW'(i);
      end
    end
  end

  assign read_idx = RdW'(in_word_i.read_index);
  assign read_hit = (read_idx < RdW'(count_q)) && (read_idx < RdW'(KEEP_DEPTH));

  always_comb begin
    read_entry = '0;
    for (int i = 0; i < KEEP_DEPTH; i++) begin
      if (RdW'(i) == read_idx) begin
        read_entry = cell_entry[i];
      end
    end
  end

  always_comb begin
    tracking_d = tracking_q;
    open_d     = open_q;
    count_d    = count_q;
    total_d    = total_q;
    out_word_d = out_word_q;
    if (accept) begin
      out_word_d          = '0;
      out_word_d.status   = ST_STARTED;
      case (in_word_i.command)
        CMD_START: begin
          open_d     = in_word_i.timestamp;
          tracking_d = 1'b1;
        end
        CMD_END: begin
          if (!tracking_q) begin
            out_word_d.status = ST_IGNORED;
          end else begin
            tracking_d = 1'b0;
            total_d    = total_sat;
            if (discard) begin
              out_word_d.status = ST_DISCARDED;
            end else begin
              out_word_d.status   = ST_INSERTED;
              out_word_d.position = ins_pos[2:0];
              if (count_q < CntW'(KEEP_DEPTH)) begin
                count_d = count_q + 1'b1;
              end
            end
          end
        end
        CMD_READ: begin
          out_word_d.position = in_word_i.read_index;
          if (read_hit) begin
            out_word_d.status         = ST_READ;
            out_word_d.entry_duration = read_entry.duration;
            out_word_d.entry_start    = read_entry.start;
            out_word_d.entry_site     = read_entry.site;
          end else begin
            out_word_d.status = ST_EMPTY;
          end
        end
        CMD_CLEAR: begin
          count_d           = '0;
          total_d           = '0;
          open_d            = '0;
          tracking_d        = 1'b0;
          out_word_d.status = ST_CLEARED;
        end
        default: begin
          out_word_d.status = ST_IGNORED;
        end
      endcase
      count_ext               = CxW'(count_d);
      out_word_d.entry_count  = count_ext[3:0];
      out_word_d.total_ticks  = total_d;
    end else begin
      count_ext = '0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tracking_q  <= 1'b0;
      open_q      <= '0;
      count_q     <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      tracking_q  <= tracking_d;
      open_q      <= open_d;
      count_q     <= count_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
  end

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(KEEP_DEPTH))
    else $error("kept count exceeds list depth");

  a_keep_prefix : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (keep_vec & ~prev_keep_vec) == '0)
    else $error("kept entries are not sorted");

  a_clear_empties : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_word_i.command == CMD_CLEAR) |=>
      (count_q == '0) && (total_q == '0) && !tracking_q)
    else $error("clear left state behind");

  a_accept_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted word produced no result");

  a_end_disarms : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ins.en |=> !tracking_q)
    else $error("tracking still armed after end");

endmodule

`default_nettype wire

### src/ltk_cell.sv
// One rank of the sorted interval list: holds one entry and decides whether
// it stays, takes the new interval or takes its upper neighbor's entry.
// Depends on ltk_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ltk_cell (
  input  wire                 clk_i,
  input  ltk_pkg::ltk_ins_t   ins_i,
  input  wire                 occupied_i,
  input  wire                 prev_keep_i,
  input  ltk_pkg::ltk_entry_t prev_entry_i,
  output logic                keep_o,
  output ltk_pkg::ltk_entry_t entry_o
);
  import ltk_pkg::*;

  ltk_entry_t entry_q;
  ltk_entry_t entry_d;

  assign keep_o  = occupied_i && (entry_q.duration >= ins_i.entry.duration);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ins_i.en && !keep_o) begin
      if (prev_keep_i) begin
        entry_d = ins_i.entry;
      end else begin
        entry_d = prev_entry_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

`default_nettype wire
